// ===== design/matrix_vector_multiply_engine_defines.svh =====
// Assertion macros shared by the matrix-vector multiply engine modules.
`ifndef MATRIX_VECTOR_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_ENGINE_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define MVME_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define MVME_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define MVME_ASSERT(lbl, prop, msg)
`define MVME_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== design/mvme_pkg.sv =====
// Types and constants of the matrix-vector multiply engine.
package mvme_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;

    localparam logic [CNT_W-1:0] CNT_RESET   = 5'd16;
    localparam logic [CNT_W-1:0] VCOUNT_MAX  = 5'd31;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COL_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_SCALE  = 2'd2,
        ACT_VECTOR = 2'd3
    } t_action;

    typedef struct packed {
        t_action                  action;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] operand;
        logic                     vector_last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [IDX_W-1:0]         result_row;
        logic                     error;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic             index;
        logic [CNT_W-1:0] data;
    } t_cfg_item;

    typedef enum logic [1:0] {
        SRC_ERROR,
        SRC_STORE,
        SRC_ACC
    } t_out_src;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ERR,
        S_RD_OUT,
        S_SCALE,
        S_MAC,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic     issue;
        logic     issue_scale;
        logic     st_wr;
        logic     st_rd;
        logic     acc_rd;
        logic     acc_clear;
        logic     out_load;
        t_out_src out_src;
        logic     out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

// ===== design/mvme_chan_if.sv =====
// Valid/ready channel carrying one payload item.
interface mvme_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mvme_dp.sv =====
// Datapath: element store, row accumulators, multiply-accumulate pipe, result register.
`include "matrix_vector_multiply_engine_defines.svh"
module mvme_dp #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mvme_pkg::t_dp_cmd                      i_cmd,
    output mvme_pkg::t_dp_status                   o_status,
    input  logic [AW-1:0]                          i_st_addr,
    input  logic [RIW-1:0]                         i_acc_row,
    input  logic [mvme_pkg::IDX_W-1:0]             i_out_row,
    input  logic signed [mvme_pkg::DATA_W-1:0]     i_operand,
    mvme_chan_if.source                            o_out
);
    localparam int SD = MAX_ROWS * MAX_COLS;
    localparam int DW = mvme_pkg::DATA_W;

    logic [DW-1:0]       r_store [SD];
    logic [DW-1:0]       r_acc [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_acc_vld;

    logic [DW-1:0]  r_st_q;
    logic [DW-1:0]  r_acc_q;
    logic           r_acc_vq;

    logic           r_p1_vld;
    logic           r_p1_scale;
    logic [AW-1:0]  r_p1_addr;
    logic [RIW-1:0] r_p1_row;
    logic           r_p2_vld;
    logic           r_p2_scale;
    logic [AW-1:0]  r_p2_addr;
    logic [RIW-1:0] r_p2_row;
    logic [DW-1:0]  r_p2_acc;
    logic [DW-1:0]  r_prod;

    logic                r_out_vld;
    mvme_pkg::t_out_item r_out;
    mvme_pkg::t_out_item n_out;

    logic          st_we;
    logic [AW-1:0] st_wa;
    logic [DW-1:0] st_wd;
    logic          st_re;
    logic          acc_we;
    logic          acc_re;
    logic [DW-1:0] acc_eff;

    // The store has one write port shared by direct writes and scale write-back.
    assign st_we  = i_cmd.st_wr | (r_p2_vld & r_p2_scale);
    assign st_wa  = i_cmd.st_wr ? i_st_addr : r_p2_addr;
    assign st_wd  = i_cmd.st_wr ? $unsigned(i_operand) : r_prod;
    assign st_re  = i_cmd.st_rd | i_cmd.issue;
    assign acc_we = r_p2_vld & ~r_p2_scale;
    assign acc_re = i_cmd.acc_rd | (i_cmd.issue & ~i_cmd.issue_scale);

    // An accumulator row never written since the last clear reads as zero.
    assign acc_eff = r_acc_vq ? r_acc_q : '0;

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= st_wd;
        end
        if (st_re) begin
            r_st_q <= r_store[i_st_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_we) begin
            r_acc[r_p2_row] <= r_p2_acc + r_prod;
        end
        if (acc_re) begin
            r_acc_q  <= r_acc[i_acc_row];
            r_acc_vq <= r_acc_vld[i_acc_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (i_cmd.acc_clear) begin
            r_acc_vld <= '0;
        end else if (acc_we) begin
            r_acc_vld[r_p2_row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_cmd.issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_scale <= i_cmd.issue_scale;
        r_p1_addr  <= i_st_addr;
        r_p1_row   <= i_acc_row;
        r_p2_scale <= r_p1_scale;
        r_p2_addr  <= r_p1_addr;
        r_p2_row   <= r_p1_row;
        r_p2_acc   <= acc_eff;
        r_prod     <= r_st_q * $unsigned(i_operand);
    end

    always_comb begin
        n_out.last = i_cmd.out_last;
        case (i_cmd.out_src)
            mvme_pkg::SRC_STORE: begin
                n_out.result_value = $signed(r_st_q);
                n_out.result_row   = i_out_row;
                n_out.error        = 1'b0;
            end
            mvme_pkg::SRC_ACC: begin
                n_out.result_value = $signed(acc_eff);
                n_out.result_row   = i_out_row;
                n_out.error        = 1'b0;
            end
            default: begin
                n_out.result_value = '0;
                n_out.result_row   = '0;
                n_out.error        = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.payload      = r_out;
    assign o_status.out_free  = ~r_out_vld | o_out.ready;
    assign o_status.pipe_busy = r_p1_vld | r_p2_vld;

    `MVME_ASSERT_NEVER(a_store_port_clash, i_cmd.st_wr && r_p2_vld && r_p2_scale, "direct write collides with scale write-back")
    `MVME_ASSERT_NEVER(a_clear_while_busy, i_cmd.acc_clear && (r_p1_vld || r_p2_vld), "accumulators cleared with products in flight")
    `MVME_ASSERT(a_p2_follows_p1, r_p2_vld |-> $past(r_p1_vld), "write-back stage valid without a product stage before it")
endmodule

// ===== design/mvme_ctrl.sv =====
// Controller: input decode, walk counters, configuration registers and sequencing.
`include "matrix_vector_multiply_engine_defines.svh"
module mvme_ctrl #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    mvme_chan_if.sink                          i_in,
    mvme_chan_if.sink                          i_cfg,
    input  mvme_pkg::t_dp_status               i_status,
    output mvme_pkg::t_dp_cmd                  o_cmd,
    output logic [AW-1:0]                      o_st_addr,
    output logic [RIW-1:0]                     o_acc_row,
    output logic [mvme_pkg::IDX_W-1:0]         o_out_row,
    output logic signed [mvme_pkg::DATA_W-1:0] o_operand
);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CW    = $clog2(MAX_COLS + 1);
    localparam int IDX_W = mvme_pkg::IDX_W;
    localparam int CNT_W = mvme_pkg::CNT_W;

    mvme_pkg::t_state   r_state;
    mvme_pkg::t_state   n_state;
    mvme_pkg::t_in_item r_item;
    logic [CNT_W-1:0]   r_row_count;
    logic [CNT_W-1:0]   r_col_count;
    logic [RW-1:0]      r_row;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      r_col;
    logic [CW-1:0]      n_col;
    logic [CNT_W-1:0]   r_vcount;
    logic [CNT_W-1:0]   n_vcount;

    logic          in_acc;
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    logic          row_ok;
    logic          col_ok;
    logic          row_last;
    logic          col_last;
    logic          len_bad;
    logic          run_end;

    assign in_acc = i_in.valid && i_in.ready;

    // Registers in force: zero counts as one, above the maximum clamps to it.
    always_comb begin
        if (r_row_count == '0) begin
            nr = RW'(1);
        end else if (int'(r_row_count) > MAX_ROWS) begin
            nr = RW'(MAX_ROWS);
        end else begin
            nr = RW'(r_row_count);
        end
        if (r_col_count == '0) begin
            nc = CW'(1);
        end else if (int'(r_col_count) > MAX_COLS) begin
            nc = CW'(MAX_COLS);
        end else begin
            nc = CW'(r_col_count);
        end
    end

    assign row_ok   = int'(r_item.row_index) < int'(nr);
    assign col_ok   = int'(r_item.col_index) < int'(nc);
    assign row_last = (int'(r_row) + 1) == int'(nr);
    assign col_last = (int'(r_col) + 1) == int'(nc);
    assign len_bad  = int'(r_vcount) != int'(nc);
    assign run_end  = (r_item.action == mvme_pkg::ACT_VECTOR) && r_item.vector_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= mvme_pkg::CNT_RESET;
            r_col_count <= mvme_pkg::CNT_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.payload.index == mvme_pkg::CFG_ROW_COUNT) begin
                r_row_count <= i_cfg.payload.data;
            end else begin
                r_col_count <= i_cfg.payload.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in.payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mvme_pkg::S_IDLE;
            r_row    <= '0;
            r_col    <= '0;
            r_vcount <= '0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_vcount <= n_vcount;
        end
    end

    // Next state and walk counters.
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_vcount = r_vcount;
        case (r_state)
            mvme_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = mvme_pkg::S_DECODE;
                end
            end
            mvme_pkg::S_DECODE: begin
                case (r_item.action)
                    mvme_pkg::ACT_WRITE: begin
                        n_state = (row_ok && col_ok) ? mvme_pkg::S_IDLE : mvme_pkg::S_ERR;
                    end
                    mvme_pkg::ACT_READ: begin
                        n_state = (row_ok && col_ok) ? mvme_pkg::S_RD_OUT : mvme_pkg::S_ERR;
                    end
                    mvme_pkg::ACT_SCALE: begin
                        n_row   = '0;
                        n_col   = '0;
                        n_state = mvme_pkg::S_SCALE;
                    end
                    mvme_pkg::ACT_VECTOR: begin
                        if (col_ok) begin
                            n_row   = '0;
                            n_state = mvme_pkg::S_MAC;
                        end else begin
                            n_vcount = '0;
                            n_state  = mvme_pkg::S_ERR;
                        end
                    end
                    default: begin
                        n_state = mvme_pkg::S_IDLE;
                    end
                endcase
            end
            mvme_pkg::S_ERR, mvme_pkg::S_RD_OUT: begin
                if (i_status.out_free) begin
                    n_state = mvme_pkg::S_IDLE;
                end
            end
            mvme_pkg::S_SCALE: begin
                if (col_last) begin
                    n_col = '0;
                    if (row_last) begin
                        n_state = mvme_pkg::S_DRAIN;
                    end else begin
                        n_row = r_row + RW'(1);
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            mvme_pkg::S_MAC: begin
                if (row_last) begin
                    n_state = mvme_pkg::S_DRAIN;
                    if (r_vcount != mvme_pkg::VCOUNT_MAX) begin
                        n_vcount = r_vcount + CNT_W'(1);
                    end
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            mvme_pkg::S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    if (run_end && len_bad) begin
                        n_vcount = '0;
                        n_state  = mvme_pkg::S_ERR;
                    end else if (run_end) begin
                        n_row   = '0;
                        n_state = mvme_pkg::S_EMIT_RD;
                    end else begin
                        n_state = mvme_pkg::S_IDLE;
                    end
                end
            end
            mvme_pkg::S_EMIT_RD: begin
                n_state = mvme_pkg::S_EMIT_OUT;
            end
            mvme_pkg::S_EMIT_OUT: begin
                if (i_status.out_free) begin
                    if (row_last) begin
                        n_vcount = '0;
                        n_state  = mvme_pkg::S_IDLE;
                    end else begin
                        n_row   = r_row + RW'(1);
                        n_state = mvme_pkg::S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = mvme_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath commands and handshake outputs.
    always_comb begin
        o_cmd         = '0;
        o_cmd.out_src = mvme_pkg::SRC_ERROR;
        i_in.ready    = 1'b0;
        case (r_state)
            mvme_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
            end
            mvme_pkg::S_DECODE: begin
                if (r_item.action == mvme_pkg::ACT_WRITE) begin
                    o_cmd.st_wr = row_ok && col_ok;
                end
                if (r_item.action == mvme_pkg::ACT_READ) begin
                    o_cmd.st_rd = row_ok && col_ok;
                end
                if (r_item.action == mvme_pkg::ACT_VECTOR) begin
                    o_cmd.acc_clear = !col_ok;
                end
            end
            mvme_pkg::S_ERR: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_src  = mvme_pkg::SRC_ERROR;
                o_cmd.out_last = 1'b1;
            end
            mvme_pkg::S_RD_OUT: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_src  = mvme_pkg::SRC_STORE;
                o_cmd.out_last = 1'b1;
            end
            mvme_pkg::S_SCALE: begin
                o_cmd.issue       = 1'b1;
                o_cmd.issue_scale = 1'b1;
            end
            mvme_pkg::S_MAC: begin
                o_cmd.issue = 1'b1;
            end
            mvme_pkg::S_DRAIN: begin
                o_cmd.acc_clear = !i_status.pipe_busy && run_end && len_bad;
            end
            mvme_pkg::S_EMIT_RD: begin
                o_cmd.acc_rd = 1'b1;
            end
            mvme_pkg::S_EMIT_OUT: begin
                o_cmd.out_load  = i_status.out_free;
                o_cmd.out_src   = mvme_pkg::SRC_ACC;
                o_cmd.out_last  = row_last;
                o_cmd.acc_clear = i_status.out_free && row_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            mvme_pkg::S_SCALE: begin
                o_st_addr = AW'(int'(r_row) * MAX_COLS + int'(r_col));
            end
            mvme_pkg::S_MAC: begin
                o_st_addr = AW'(int'(r_row) * MAX_COLS + int'(r_item.col_index));
            end
            default: begin
                o_st_addr = AW'(int'(r_item.row_index) * MAX_COLS + int'(r_item.col_index));
            end
        endcase
    end

    assign o_acc_row = r_row[RIW-1:0];
    assign o_out_row = (r_state == mvme_pkg::S_RD_OUT) ? r_item.row_index : IDX_W'(r_row);
    assign o_operand = r_item.operand;
    assign i_cfg.ready = 1'b1;

    `MVME_ASSERT(a_load_when_free, o_cmd.out_load |-> i_status.out_free, "result loaded into a full output register")
    `MVME_ASSERT(a_idle_pipe_empty, (r_state == mvme_pkg::S_IDLE) |-> !i_status.pipe_busy, "idle with products still in flight")
    `MVME_ASSERT(a_emit_row_bound, (r_state == mvme_pkg::S_EMIT_OUT) |-> (int'(r_row) < int'(nr)), "emitting a row beyond the rows in use")
endmodule

// ===== design/matrix_vector_multiply_engine.sv =====
// Top level of the matrix-vector multiply engine.
// Usage:
//   i_in carries one item per handshake: write element, read element, scale all, or
//   one vector element. i_cfg writes row_count (index 0) or col_count (index 1); it is
//   always ready; the user must write it only while the engine is idle, and the engine
//   does not enforce this. o_out carries results.
// Sequencing (one item at a time, ready only between items):
//   write: stored at decode; read: element read at decode. A read result or an
//     out-of-range error is loaded into the output register once that register is free.
//   vector element: the single multiply-accumulate unit takes one row per cycle,
//     then its two-stage pipe drains. last vector element: emits one result per row
//     in use, or an error if the count differs. scale: rows * cols in use elements,
//     one element per cycle through the same unit and the single store write port.
// Reset: row_count and col_count return to 16, accumulators and the vector count clear;
//   the element store keeps no reset value and must be written before use.
// Stall: results wait in the output register; the engine holds until it drains, and
//   a new item is accepted while the last result still waits.
module matrix_vector_multiply_engine #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvme_chan_if.sink   i_in,
    mvme_chan_if.sink   i_cfg,
    mvme_chan_if.source o_out
);
    localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

    mvme_pkg::t_dp_cmd                  cmd;
    mvme_pkg::t_dp_status               status;
    logic [AW-1:0]                      st_addr;
    logic [RIW-1:0]                     acc_row;
    logic [mvme_pkg::IDX_W-1:0]         out_row;
    logic signed [mvme_pkg::DATA_W-1:0] operand;

    mvme_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_st_addr (st_addr),
        .o_acc_row (acc_row),
        .o_out_row (out_row),
        .o_operand (operand)
    );

    mvme_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_status  (status),
        .i_st_addr (st_addr),
        .i_acc_row (acc_row),
        .i_out_row (out_row),
        .i_operand (operand),
        .o_out     (o_out)
    );
endmodule

// ===== bench/matrix_vector_multiply_engine_tb.sv =====
// Self-checking testbench of the matrix-vector multiply engine with its own predictor.
module matrix_vector_multiply_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mvme_pkg::*;

    localparam int MAX_R       = 16;
    localparam int MAX_C       = 16;
    localparam int DIR_N       = 24;
    localparam int N_PHASES    = 6;
    localparam int PHASE_QUOTA = 5;
    // Longest silent stretch: a full scale pass plus a full product drain.
    localparam int DRAIN_CYC   = MAX_R * MAX_C + 2 * MAX_R + 64;
    localparam int LIMIT_CYC   = 3_000_000;

    localparam t_out_item ERR_RES = '{result_value: '0, result_row: '0, error: 1'b1,
                                      last: 1'b1};
    // Mostly small shapes keep the entries that must be loaded before use few.
    localparam int PH_ROWS [N_PHASES] = '{0, 2, 3, 17, 5, 0};
    localparam int PH_COLS [N_PHASES] = '{0, 31, 5, 1, 0, 0};

    typedef struct packed {
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_stim;

    typedef struct packed {
        logic      is_cfg;
        t_cfg_item cfg;
        t_in_item  item;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    mvme_chan_if #(.t_payload(t_in_item))  in_ch ();
    mvme_chan_if #(.t_payload(t_cfg_item)) cfg_ch ();
    mvme_chan_if #(.t_payload(t_out_item)) out_ch ();

    matrix_vector_multiply_engine #(
        .MAX_ROWS (MAX_R),
        .MAX_COLS (MAX_C)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // Predictor state
    logic [DATA_W-1:0] matrix  [MAX_R][MAX_C];
    logic [DATA_W-1:0] row_acc [MAX_R];
    logic [CNT_W-1:0]  vec_count;
    logic [CNT_W-1:0]  row_cfg;
    logic [CNT_W-1:0]  col_cfg;
    t_out_item         step_out [$];
    t_out_item         due_results [$];

    // Stimulus side
    bit       loaded [MAX_R][MAX_C];
    t_stim    in_pend [$];
    t_stim    in_cur;
    bit       in_taken;
    bit       steady;
    t_dir_row dir_tab [DIR_N];

    int fails;
    int n_items;
    int n_results;
    int n_flagged;
    int n_cfg;

    function automatic int unsigned rows_live();
        if (row_cfg == 0) return 1;
        if (row_cfg > MAX_R) return MAX_R;
        return row_cfg;
    endfunction

    function automatic int unsigned cols_live();
        if (col_cfg == 0) return 1;
        if (col_cfg > MAX_C) return MAX_C;
        return col_cfg;
    endfunction

    task automatic drop_run();
        foreach (row_acc[i]) row_acc[i] = '0;
        vec_count = '0;
    endtask

    task automatic engine_step(input t_in_item it);
        int unsigned nr;
        int unsigned nc;
        t_out_item   o;
        step_out.delete();
        nr = rows_live();
        nc = cols_live();
        case (it.action)
            ACT_WRITE, ACT_READ: begin
                if (it.row_index >= nr || it.col_index >= nc) begin
                    step_out.push_back(ERR_RES);
                end else if (it.action == ACT_WRITE) begin
                    matrix[it.row_index][it.col_index] = it.operand;
                end else begin
                    o.result_value = matrix[it.row_index][it.col_index];
                    o.result_row   = it.row_index;
                    o.error        = 1'b0;
                    o.last         = 1'b1;
                    step_out.push_back(o);
                end
            end
            ACT_SCALE: begin
                for (int i = 0; i < nr; i++)
                    for (int j = 0; j < nc; j++)
                        matrix[i][j] = matrix[i][j] * it.operand;
            end
            ACT_VECTOR: begin
                if (it.col_index >= nc) begin
                    drop_run();
                    step_out.push_back(ERR_RES);
                end else begin
                    for (int i = 0; i < nr; i++)
                        row_acc[i] = row_acc[i] + matrix[i][it.col_index] * it.operand;
                    if (vec_count < VCOUNT_MAX) vec_count++;
                    if (it.vector_last) begin
                        if (vec_count != nc) begin
                            step_out.push_back(ERR_RES);
                        end else begin
                            for (int i = 0; i < nr; i++) begin
                                o.result_value = row_acc[i];
                                o.result_row   = i[IDX_W-1:0];
                                o.error        = 1'b0;
                                o.last         = (i == nr - 1);
                                step_out.push_back(o);
                            end
                        end
                        drop_run();
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic int idle_len();
        int p;
        if (steady) return 0;
        p = $urandom_range(0, 99);
        if (p < 65) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 16) - 8;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in_item mk_item(t_action a, int r, int c, logic [DATA_W-1:0] v,
                                         logic vl);
        t_in_item it;
        it.action      = a;
        it.row_index   = r[IDX_W-1:0];
        it.col_index   = c[IDX_W-1:0];
        it.operand     = v;
        it.vector_last = vl;
        return it;
    endfunction

    function automatic t_dir_row drow(t_action a, int r, int c, logic [DATA_W-1:0] v,
                                      logic vl, logic typed = 1'b0,
                                      t_out_item want = '0);
        t_dir_row d;
        d       = '0;
        d.item  = mk_item(a, r, c, v, vl);
        d.typed = typed;
        d.want  = want;
        return d;
    endfunction

    function automatic t_dir_row crow(logic idx, int data);
        t_dir_row d;
        d            = '0;
        d.is_cfg     = 1'b1;
        d.cfg.index  = idx;
        d.cfg.data   = data[CNT_W-1:0];
        return d;
    endfunction

    task automatic queue_item(input t_in_item it, input logic typed = 1'b0,
                              input t_out_item want = '0);
        t_stim s;
        s.item  = it;
        s.typed = typed;
        s.want  = want;
        if (it.action == ACT_WRITE && it.row_index < rows_live() &&
            it.col_index < cols_live())
            loaded[it.row_index][it.col_index] = 1'b1;
        in_pend.push_back(s);
    endtask

    // Load every entry of a column that a vector element is about to touch.
    task automatic fill_column(input int c);
        for (int i = 0; i < rows_live(); i++)
            if (!loaded[i][c])
                queue_item(mk_item(ACT_WRITE, i, c, rand_word(), $urandom_range(0, 1)));
    endtask

    task automatic pick_outside(input int nr, input int nc, output int r, output int c);
        if (nr < MAX_R && (nc == MAX_C || $urandom_range(0, 1) == 1)) begin
            r = $urandom_range(nr, MAX_R - 1);
            c = $urandom_range(0, MAX_C - 1);
        end else begin
            r = $urandom_range(0, MAX_R - 1);
            c = $urandom_range(nc, MAX_C - 1);
        end
    endtask

    task automatic settle();
        while (in_pend.size() != 0 || in_ch.valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] data);
        settle();
        @(negedge i_clk);
        cfg_ch.payload <= '{index: idx, data: data};
        cfg_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid   <= 1'b0;
    endtask

    task automatic random_phase(input int quota);
        int      done;
        int      pick;
        int      len;
        int      nr;
        int      nc;
        int      r;
        int      c;
        t_action act;
        done = 0;
        while (done < quota) begin
            nr   = rows_live();
            nc   = cols_live();
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // Mostly well-formed runs; the rest too short or too long.
                if (pick < 42) len = nc;
                else if (pick < 46) len = nc + 32;  // count saturates instead of wrapping
                else begin
                    len = $urandom_range(1, nc + 3);
                    if (len == nc) len = nc + 1;
                end
                for (int k = 0; k < len; k++) begin
                    c = (pick < 42 && pick % 2 == 1) ? k : $urandom_range(0, nc - 1);
                    fill_column(c);
                    queue_item(mk_item(ACT_VECTOR, $urandom_range(0, MAX_R - 1), c,
                                       rand_word(), k == len - 1));
                end
                done += len;
            end else if (pick < 62 && nc < MAX_C) begin
                // Abandon a run part way with a position beyond the columns in use.
                len = $urandom_range(0, nc - 1);
                for (int k = 0; k < len; k++) begin
                    c = $urandom_range(0, nc - 1);
                    fill_column(c);
                    queue_item(mk_item(ACT_VECTOR, $urandom_range(0, MAX_R - 1), c,
                                       rand_word(), 1'b0));
                end
                queue_item(mk_item(ACT_VECTOR, $urandom_range(0, MAX_R - 1),
                                   $urandom_range(nc, MAX_C - 1), rand_word(),
                                   $urandom_range(0, 1)));
                done += len + 1;
            end else if (pick < 92) begin
                act = (pick < 77) ? ACT_READ : ACT_WRITE;
                if ((nr < MAX_R || nc < MAX_C) && $urandom_range(0, 4) == 0) begin
                    pick_outside(nr, nc, r, c);
                end else begin
                    r = $urandom_range(0, nr - 1);
                    c = $urandom_range(0, nc - 1);
                    if (act == ACT_READ && !loaded[r][c])
                        queue_item(mk_item(ACT_WRITE, r, c, rand_word(), 1'b0));
                end
                queue_item(mk_item(act, r, c, rand_word(), $urandom_range(0, 1)));
                done++;
            end else begin
                queue_item(mk_item(ACT_SCALE, $urandom_range(0, MAX_R - 1),
                                   $urandom_range(0, MAX_C - 1),
                                   ($urandom_range(0, 3) == 0) ? rand_word()
                                                               : $urandom_range(0, 6) - 3,
                                   $urandom_range(0, 1)));
                done++;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Input side: hold each item until taken, then idle for a random gap.
    initial begin : drive_in
        int in_gap;
        in_gap         = 0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && (!in_ch.valid || in_taken)) begin
                if (in_gap > 0) begin
                    in_ch.valid <= 1'b0;
                    in_gap--;
                end else if (in_pend.size() != 0) begin
                    in_cur         = in_pend.pop_front();
                    in_ch.payload <= in_cur.item;
                    in_ch.valid   <= 1'b1;
                    in_gap         = idle_len();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    initial begin : drive_out
        int out_stall;
        out_stall    = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (out_stall > 0) begin
                out_ch.ready <= 1'b0;
                out_stall--;
            end else begin
                out_ch.ready <= 1'b1;
                out_stall = idle_len();
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_out_item got;
        t_out_item w;
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (due_results.size() == 0) begin
                    $error("unexpected result: value %0d row %0d error %0b last %0b",
                           got.result_value, got.result_row, got.error, got.last);
                    fails++;
                end else begin
                    w = due_results.pop_front();
                    if (got.result_value !== w.result_value) begin
                        $error("result_value: expected %0d, got %0d",
                               w.result_value, got.result_value);
                        fails++;
                    end
                    if (got.result_row !== w.result_row) begin
                        $error("result_row: expected %0d, got %0d", w.result_row,
                               got.result_row);
                        fails++;
                    end
                    if (got.error !== w.error) begin
                        $error("error: expected %0b, got %0b", w.error, got.error);
                        fails++;
                    end
                    if (got.last !== w.last) begin
                        $error("last: expected %0b, got %0b", w.last, got.last);
                        fails++;
                    end
                    n_results++;
                    if (w.error) n_flagged++;
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.payload.index == CFG_ROW_COUNT) row_cfg = cfg_ch.payload.data;
                else col_cfg = cfg_ch.payload.data;
                n_cfg++;
            end
            in_taken = in_ch.valid && in_ch.ready;
            if (in_taken) begin
                engine_step(in_ch.payload);
                n_items++;
                if (in_cur.typed) due_results.push_back(in_cur.want);
                else foreach (step_out[k]) due_results.push_back(step_out[k]);
            end
        end
    end

    initial begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < LIMIT_CYC) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("matrix_vector_multiply_engine regression: fail");
        $finish;
    end

    initial begin : main
        int r;
        int c;
        i_rst_n        = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.payload = '0;
        steady         = 1'b0;
        row_cfg        = CNT_RESET;
        col_cfg        = CNT_RESET;
        drop_run();

        dir_tab = '{
            drow(ACT_WRITE, 0, 0, 32'h7FFF_FFFF, 1'b0),
            drow(ACT_READ, 0, 0, 32'h0, 1'b1, 1'b1,
                 t_out_item'{32'h7FFF_FFFF, 4'd0, 1'b0, 1'b1}),
            drow(ACT_WRITE, 15, 15, 32'h8000_0000, 1'b1),
            drow(ACT_READ, 15, 15, 32'hFFFF_FFFF, 1'b0, 1'b1,
                 t_out_item'{32'h8000_0000, 4'd15, 1'b0, 1'b1}),
            crow(CFG_ROW_COUNT, 2),
            crow(CFG_COL_COUNT, 3),
            drow(ACT_WRITE, 2, 0, 32'h1234_5678, 1'b0, 1'b1, ERR_RES),
            drow(ACT_READ, 0, 3, 32'h0, 1'b0, 1'b1, ERR_RES),
            drow(ACT_READ, 15, 15, 32'h0, 1'b0, 1'b1, ERR_RES),
            drow(ACT_WRITE, 1, 0, 5, 1'b0),
            drow(ACT_WRITE, 0, 1, -1, 1'b0),
            drow(ACT_WRITE, 1, 1, 3, 1'b0),
            drow(ACT_WRITE, 0, 2, 2, 1'b0),
            drow(ACT_WRITE, 1, 2, -7, 1'b0),
            drow(ACT_SCALE, 9, 9, -3, 1'b1),
            drow(ACT_READ, 1, 1, 32'h0, 1'b0),
            // in-order run with extreme operands
            drow(ACT_VECTOR, 0, 0, 2, 1'b0),
            drow(ACT_VECTOR, 0, 1, 32'h8000_0000, 1'b0),
            drow(ACT_VECTOR, 0, 2, -1, 1'b1),
            drow(ACT_VECTOR, 0, 5, 7, 1'b0, 1'b1, ERR_RES),
            drow(ACT_VECTOR, 0, 0, 1, 1'b1, 1'b1, ERR_RES),
            // repeated positions out of order still count to the column total
            drow(ACT_VECTOR, 0, 2, 32'h7FFF_FFFF, 1'b0),
            drow(ACT_VECTOR, 0, 2, -2, 1'b0),
            drow(ACT_VECTOR, 0, 0, 32'h0, 1'b1)
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) write_reg(dir_tab[k].cfg.index, dir_tab[k].cfg.data);
            else queue_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            r = PH_ROWS[p];
            c = PH_COLS[p];
            if (p == N_PHASES - 1) begin
                r = $urandom_range(0, 31);
                c = $urandom_range(0, 2);
            end
            steady = ($urandom_range(0, 3) == 0);
            write_reg(CFG_ROW_COUNT, r[CNT_W-1:0]);
            write_reg(CFG_COL_COUNT, c[CNT_W-1:0]);
            random_phase(PHASE_QUOTA);
        end

        settle();
        $display("Covered %0d input items across %0d register writes.", n_items, n_cfg);
        $display("Checked %0d results, %0d of them error flags.", n_results, n_flagged);
        if (fails == 0) $display("matrix_vector_multiply_engine regression: pass");
        else $display("matrix_vector_multiply_engine regression: fail");
        $finish;
    end

endmodule
